>>> rtl/core/ipf_pkg.sv
// ----------------------------------------------------------------------------
// Integer printf formatter package
// Shared constants and types for the integer printf formatter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int unsigned MaxPadDefault = 48;

  // Conversion codes.
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_OCT  = 3'd2;
  localparam logic [2:0] OP_HEXL = 3'd3;
  localparam logic [2:0] OP_HEXU = 3'd4;
  localparam logic [2:0] OP_PTR  = 3'd5;

  // Length modes.
  localparam logic [1:0] LM_32 = 2'd0;
  localparam logic [1:0] LM_16 = 2'd1;
  localparam logic [1:0] LM_64 = 2'd2;

  // Input item.
  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  opcode;
    logic [1:0]  length_mode;
    logic        left_justify;
    logic        show_plus;
    logic        show_space;
    logic        alternate_form;
    logic        zero_pad;
    logic [5:0]  field_width;
    logic        precision_given;
    logic [5:0]  min_digits;
  } ipf_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       empty_res;
  } ipf_out_t;

  // Character of one digit value.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = {4'd0, d} + 8'd55;
    else c = {4'd0, d} + 8'd87;
    return c;
  endfunction

  // Characters of the null pointer text.
  function automatic logic [7:0] nil_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6C;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/ipf_in_if.sv
// ----------------------------------------------------------------------------
// Integer printf formatter input channel
// Valid/ready channel that carries one value with its format settings.
// ----------------------------------------------------------------------------
interface ipf_in_if;
  logic             valid;
  logic             ready;
  ipf_pkg::ipf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ipf_out_if.sv
// ----------------------------------------------------------------------------
// Integer printf formatter output channel
// Valid/ready channel that carries one formatted character.
// ----------------------------------------------------------------------------
interface ipf_out_if;
  logic              valid;
  logic              ready;
  ipf_pkg::ipf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/integer_printf_formatter.sv
// ----------------------------------------------------------------------------
// Integer printf formatter
// Formats one integer as printf %d %u %o %x %X %p and streams the text.
// ----------------------------------------------------------------------------
// Usage:
// One item enters on in_ch (value, conversion code, flags, width and
// precision). The text leaves on out_ch as one character per transfer, the
// final one marked by last. An empty text gives a single transfer with
// empty_res set.
// Operation: after a transfer in, the value is cut into digits by one
// shared digit unit. Octal and hex take one digit step per digit (up to 22
// digits for octal of a 64-bit value, 16 for hex). Decimal uses a
// divide-by-ten step built from a shift-and-add reciprocal, split over the
// ST_DIG and ST_DIV2 states for each digit (up to 20 digits). A value that
// prints no digits still takes one digit step. A setup step then lays out
// the text, which streams at one character per cycle while the receiver
// takes it; the input is not ready until the sequencer returns to idle.
// Reset clears the sequencer to idle; no output is pending.
// When the receiver stalls, the current character holds in the output
// register and the sequencer waits.
// ----------------------------------------------------------------------------
module integer_printf_formatter #(
  parameter int unsigned MaxPad = ipf_pkg::MaxPadDefault
) (
  input logic clk_i,
  input logic rst_ni,
  ipf_in_if.sink   in_ch,
  ipf_out_if.source out_ch
);

  localparam int unsigned BufLen = MaxPad + 32;
  localparam int unsigned LenW   = $clog2(BufLen + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIG   = 5'b00010,
    ST_DIV2  = 5'b00100,
    ST_SETUP = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Captured item and working values.
  logic [2:0]  op_q;
  logic        left_q, alt_q, zpad_q, pgiven_q, nil_q, neg_q, plus_q, space_q;
  logic [5:0]  width_q, prec_q;
  logic [63:0] m_q, m_d;
  logic        magz_q;
  logic [4:0]  nd_q;
  logic [3:0]  rdig_q [24];
  logic [LenW-1:0] pos_q, total_q, pad_q, blen_q, zeros_q;
  logic [1:0]  npre_q;
  logic [7:0]  char_q;
  logic        last_q, empty_q, ovalid_q;
  logic [63:0] qt_q;

  // Input decode.
  ipf_pkg::ipf_in_t in_d;
  logic [2:0]  op_n;
  logic [5:0]  wid_n, prec_n;
  logic [63:0] mag_n;
  logic        neg_n;
  assign in_d = in_ch.data;

  always_comb begin
    op_n   = (in_d.opcode > ipf_pkg::OP_PTR) ? ipf_pkg::OP_UDEC : in_d.opcode;
    wid_n  = (32'(in_d.field_width) > MaxPad) ? 6'(MaxPad) : in_d.field_width;
    prec_n = (32'(in_d.min_digits) > MaxPad) ? 6'(MaxPad) : in_d.min_digits;
    neg_n  = 1'b0;
    if (op_n == ipf_pkg::OP_PTR) begin
      mag_n = in_d.value;
    end else if (in_d.length_mode == ipf_pkg::LM_16) begin
      mag_n = {48'd0, in_d.value[15:0]};
      if (op_n == ipf_pkg::OP_SDEC && in_d.value[15]) begin
        neg_n = 1'b1;
        mag_n = 64'h10000 - mag_n;
      end
    end else if (in_d.length_mode == ipf_pkg::LM_64) begin
      mag_n = in_d.value;
      if (op_n == ipf_pkg::OP_SDEC && in_d.value[63]) begin
        neg_n = 1'b1;
        mag_n = 64'd0 - mag_n;
      end
    end else begin
      mag_n = {32'd0, in_d.value[31:0]};
      if (op_n == ipf_pkg::OP_SDEC && in_d.value[31]) begin
        neg_n = 1'b1;
        mag_n = 64'h1_0000_0000 - mag_n;
      end
    end
  end

  // Digit unit: quotient by ten is m*0.8 shifted right by three, approximated
  // by shifts and adds, then corrected by one compare-subtract in ST_DIV2.
  logic [63:0] q_est;
  logic [67:0] r_full;
  logic [63:0] q_fix;
  logic [3:0]  r_fix;
  always_comb begin
    q_est = (m_q >> 1) + (m_q >> 2);
    q_est = q_est + (q_est >> 4);
    q_est = q_est + (q_est >> 8);
    q_est = q_est + (q_est >> 16);
    q_est = q_est + (q_est >> 32);
    q_est = q_est >> 3;
    r_full = {4'd0, m_q} - ({4'd0, qt_q} * 68'd10);
    if (r_full >= 68'd10) begin
      q_fix = qt_q + 64'd1;
      r_fix = 4'(r_full - 68'd10);
    end else begin
      q_fix = qt_q;
      r_fix = r_full[3:0];
    end
  end

  logic [3:0] dig_n;
  logic [63:0] quo_n;
  always_comb begin
    if (op_q == ipf_pkg::OP_OCT) begin
      dig_n = {1'b0, m_q[2:0]};
      quo_n = m_q >> 3;
    end else if (op_q >= ipf_pkg::OP_HEXL) begin
      dig_n = m_q[3:0];
      quo_n = m_q >> 4;
    end else begin
      dig_n = r_fix;
      quo_n = q_fix;
    end
  end

  logic is_dec;
  assign is_dec = (op_q == ipf_pkg::OP_SDEC) || (op_q == ipf_pkg::OP_UDEC);

  // Layout computed in the setup cycle.
  logic [LenW-1:0] zeros_n, blen_n, pad_n, tot_n, base_n;
  logic [1:0] npre_n;
  always_comb begin
    zeros_n = '0;
    npre_n  = 2'd0;
    base_n  = '0;
    if (nil_q) begin
      blen_n = LenW'(5);
    end else begin
      if (pgiven_q && prec_q > 6'(nd_q)) zeros_n = LenW'(prec_q) - LenW'(nd_q);
      if (op_q == ipf_pkg::OP_OCT && alt_q && zeros_n == '0 && !(nd_q == 5'd1 && magz_q))
        zeros_n = LenW'(1);
      if (op_q == ipf_pkg::OP_SDEC) begin
        npre_n = (neg_q || plus_q || space_q) ? 2'd1 : 2'd0;
      end else if ((op_q == ipf_pkg::OP_HEXL || op_q == ipf_pkg::OP_HEXU) && alt_q && !magz_q) begin
        npre_n = 2'd2;
      end else if (op_q == ipf_pkg::OP_PTR) begin
        npre_n = 2'd2;
      end
      base_n = LenW'(npre_n) + zeros_n + LenW'(nd_q);
      if (zpad_q && !left_q && !pgiven_q && LenW'(width_q) > base_n)
        zeros_n = zeros_n + (LenW'(width_q) - base_n);
      blen_n = LenW'(npre_n) + zeros_n + LenW'(nd_q);
    end
    pad_n = (LenW'(width_q) > blen_n) ? LenW'(width_q) - blen_n : '0;
    tot_n = blen_n + pad_n;
  end

  // Character at the current position.
  logic [LenW-1:0] bi;
  logic            in_body;
  logic [7:0]      ch_n;
  logic [LenW-1:0] di;
  always_comb begin
    if (left_q) begin
      in_body = pos_q < blen_q;
      bi      = pos_q;
    end else begin
      in_body = pos_q >= pad_q;
      bi      = pos_q - pad_q;
    end
    di = bi - LenW'(npre_q) - zeros_q;
    if (!in_body) begin
      ch_n = 8'h20;
    end else if (nil_q) begin
      ch_n = ipf_pkg::nil_char(bi[2:0]);
    end else if (bi < LenW'(npre_q)) begin
      if (op_q == ipf_pkg::OP_SDEC)
        ch_n = neg_q ? 8'h2D : (plus_q ? 8'h2B : 8'h20);
      else if (bi == '0)
        ch_n = 8'h30;
      else
        ch_n = (op_q == ipf_pkg::OP_HEXU) ? 8'h58 : 8'h78;
    end else if (bi < LenW'(npre_q) + zeros_q) begin
      ch_n = 8'h30;
    end else begin
      ch_n = ipf_pkg::digit_char(rdig_q[5'(LenW'(nd_q) - 1'b1 - di)],
                                 op_q == ipf_pkg::OP_HEXU);
    end
  end

  logic out_free;
  assign out_free = !ovalid_q || out_ch.ready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_d = ST_DIG;
          m_d     = mag_n;
        end
      end
      ST_DIG: begin
        if (is_dec) state_d = ST_DIV2;
        else begin
          m_d = quo_n;
          if (quo_n == 64'd0 || nd_q == 5'd23) state_d = ST_SETUP;
        end
      end
      ST_DIV2: begin
        m_d = quo_n;
        state_d = (quo_n == 64'd0 || nd_q == 5'd23) ? ST_SETUP : ST_DIG;
      end
      ST_SETUP: state_d = ST_EMIT;
      ST_EMIT: if (out_free && (pos_q + 1'b1 >= total_q || total_q == '0)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_q == ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && out_free) ovalid_q <= 1'b1;
      else if (out_ch.ready) ovalid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    m_q  <= m_d;
    qt_q <= q_est;
    if (state_q == ST_IDLE && in_ch.valid) begin
      op_q     <= op_n;
      left_q   <= in_d.left_justify;
      plus_q   <= in_d.show_plus;
      space_q  <= in_d.show_space;
      alt_q    <= in_d.alternate_form;
      zpad_q   <= in_d.zero_pad;
      pgiven_q <= in_d.precision_given;
      width_q  <= wid_n;
      prec_q   <= prec_n;
      neg_q    <= neg_n;
      magz_q   <= (mag_n == 64'd0);
      nil_q    <= (op_n == ipf_pkg::OP_PTR) && (in_d.value == 64'd0);
      nd_q     <= 5'd0;
      pos_q    <= '0;
    end
    if ((state_q == ST_DIG && !is_dec) || state_q == ST_DIV2) begin
      if (!(pgiven_q && prec_q == 6'd0 && magz_q) && !nil_q) begin
        rdig_q[nd_q] <= dig_n;
        nd_q <= nd_q + 5'd1;
      end
    end
    if (state_q == ST_SETUP) begin
      zeros_q <= zeros_n;
      npre_q  <= npre_n;
      blen_q  <= blen_n;
      pad_q   <= pad_n;
      total_q <= tot_n;
    end
    if (state_q == ST_EMIT && out_free) begin
      char_q  <= (total_q == '0) ? 8'd0 : ch_n;
      last_q  <= (total_q == '0) || (pos_q + 1'b1 == total_q);
      empty_q <= (total_q == '0);
      pos_q   <= pos_q + 1'b1;
    end
  end

  assign out_ch.valid          = ovalid_q;
  assign out_ch.data.character = char_q;
  assign out_ch.data.last      = last_q;
  assign out_ch.data.empty_res = empty_q;

`ifndef NO_ASSERTIONS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (nd_q <= 5'd22)) else $error("digit count overflow");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && empty_q) |-> last_q) else $error("empty without last");
`endif

endmodule
